// ===== hw/rtl/bba_pkg.sv =====
// shared constants and types for the buddy block allocator
// no dependencies
`default_nettype none
package bba_pkg;
  localparam int TOP_ORDER = 10;
  localparam int NW = TOP_ORDER + 1;
  localparam int NODE_COUNT = (1 << NW) - 1;
  localparam int OW = 4;
  localparam int SW = 10;

  localparam logic [1:0] ST_ABSENT = 2'd0;
  localparam logic [1:0] ST_FREE = 2'd1;
  localparam logic [1:0] ST_USED = 2'd2;
  localparam logic [1:0] ST_SPLIT = 2'd3;

  localparam logic [1:0] RS_OK = 2'd0;
  localparam logic [1:0] RS_NOFIT = 2'd1;
  localparam logic [1:0] RS_BADFREE = 2'd2;

  localparam logic [4:0] OP_NOP = 5'd0;
  localparam logic [4:0] OP_CLR = 5'd1;
  localparam logic [4:0] OP_LOAD = 5'd2;
  localparam logic [4:0] OP_RD_IDX = 5'd3;
  localparam logic [4:0] OP_RD_L = 5'd4;
  localparam logic [4:0] OP_RD_R = 5'd5;
  localparam logic [4:0] OP_NEXT = 5'd6;
  localparam logic [4:0] OP_W_SPLIT = 5'd7;
  localparam logic [4:0] OP_W_CL = 5'd8;
  localparam logic [4:0] OP_W_CR = 5'd9;
  localparam logic [4:0] OP_W_USED = 5'd10;
  localparam logic [4:0] OP_W_FREE = 5'd11;
  localparam logic [4:0] OP_PAR = 5'd12;
  localparam logic [4:0] OP_W_LA = 5'd13;
  localparam logic [4:0] OP_W_RA = 5'd14;
  localparam logic [4:0] OP_W_PF = 5'd15;
  localparam logic [4:0] OP_RESULT = 5'd16;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] rd;
    logic       lfree;
    logic       scan_last;
    logic       scan_final;
    logic       cur_gt;
    logic       idx_zero;
    logic       clr_last;
    logic       big;
    logic       bad;
    logic       kind;
  } sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bba_dp.sv =====
// datapath: node state memory, index registers and result registers
// depends on bba_pkg
`default_nettype none
module bba_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bba_pkg::cmd_t         cmd,
  output bba_pkg::sts_t              sts,
  input  wire logic                  kind,
  input  wire logic [15:0]           request_size,
  input  wire logic [9:0]            block_start,
  input  wire logic [3:0]            block_order,
  output logic                       done,
  output logic [1:0]                 status,
  output logic [9:0]                 out_start,
  output logic [3:0]                 out_order
);
  import bba_pkg::*;

  logic [1:0] mem [0:NODE_COUNT-1];
  logic [1:0] rd;
  logic [NW-1:0] idx, lb, par, clr;
  logic [OW-1:0] cur, want;
  logic lfree, big, bad, kind_q;

  logic [OW-1:0] want_c;
  logic [NW-1:0] fidx_c, aidx_c, lnode, rnode, lc, rc, waddr, raddr, fb, off, sh;
  logic [9:0] fmask;
  logic [1:0] wdata;
  logic we, re;

  always_comb begin
    want_c = OW'(TOP_ORDER);
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if ((32'd1 << i) >= 32'(request_size)) want_c = OW'(i);
    end
    aidx_c = (NW'(1) << (OW'(TOP_ORDER) - want_c)) - NW'(1);
    fidx_c = (NW'(1) << (OW'(TOP_ORDER) - block_order)) - NW'(1)
             + NW'(block_start >> block_order);
    fmask = (10'd1 << block_order) - 10'd1;
    lc = {idx[NW-2:0], 1'b1};
    rc = {idx[NW-2:0], 1'b0} + NW'(2);
    lnode = {par[NW-2:0], 1'b1};
    rnode = {par[NW-2:0], 1'b0} + NW'(2);
    fb = (NW'(1) << (OW'(TOP_ORDER) - want)) - NW'(1);
    off = idx - fb;
    sh = off << want;
  end

  always_comb begin
    we = 1'b1;
    waddr = idx;
    wdata = ST_ABSENT;
    case (cmd.op)
      OP_CLR: begin
        waddr = clr;
        wdata = (clr == '0) ? ST_FREE : ST_ABSENT;
      end
      OP_W_SPLIT: wdata = ST_SPLIT;
      OP_W_CL: begin
        waddr = lc;
        wdata = ST_FREE;
      end
      OP_W_CR: begin
        waddr = rc;
        wdata = ST_FREE;
      end
      OP_W_USED: wdata = ST_USED;
      OP_W_FREE: wdata = ST_FREE;
      OP_W_LA: waddr = lnode;
      OP_W_RA: waddr = rnode;
      OP_W_PF: begin
        waddr = par;
        wdata = ST_FREE;
      end
      default: we = 1'b0;
    endcase
    re = 1'b1;
    case (cmd.op)
      OP_RD_IDX: raddr = idx;
      OP_RD_L: raddr = lnode;
      OP_RD_R: raddr = rnode;
      default: begin
        raddr = idx;
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr <= '0;
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_RESULT);
      if (cmd.op == OP_CLR) clr <= clr + NW'(1);
    end
    case (cmd.op)
      OP_LOAD: begin
        kind_q <= kind;
        want <= want_c;
        cur <= want_c;
        big <= request_size > 16'(1 << TOP_ORDER);
        bad <= (block_order > OW'(TOP_ORDER)) || ((block_start & fmask) != 10'd0);
        idx <= kind ? fidx_c : aidx_c;
        lb <= aidx_c;
        out_start <= '0;
        out_order <= '0;
      end
      OP_RD_R: lfree <= (rd == ST_FREE);
      OP_NEXT: begin
        if (idx == {lb[NW-2:0], 1'b0}) begin
          lb <= (lb - NW'(1)) >> 1;
          idx <= (lb - NW'(1)) >> 1;
          cur <= cur + OW'(1);
        end else begin
          idx <= idx + NW'(1);
        end
      end
      OP_W_CR: begin
        idx <= lc;
        cur <= cur - OW'(1);
      end
      OP_W_USED: begin
        out_start <= sh[SW-1:0];
        out_order <= want;
      end
      OP_PAR: par <= (idx - NW'(1)) >> 1;
      OP_W_PF: idx <= par;
      OP_RESULT: status <= cmd.res;
      default: ;
    endcase
  end

  always_comb begin
    sts.rd = rd;
    sts.lfree = lfree;
    sts.scan_last = (idx == {lb[NW-2:0], 1'b0});
    sts.scan_final = (lb == '0);
    sts.cur_gt = (cur > want);
    sts.idx_zero = (idx == '0);
    sts.clr_last = (clr == NW'(NODE_COUNT - 1));
    sts.big = big;
    sts.bad = bad;
    sts.kind = kind_q;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bba_ctrl.sv =====
// controller state machine sequencing search, split and merge
// depends on bba_pkg
`default_nettype none
module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output bba_pkg::cmd_t      cmd,
  input  wire bba_pkg::sts_t sts
);
  import bba_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC = 4'd2;
  localparam logic [3:0] S_ACHK = 4'd3;
  localparam logic [3:0] S_ARD = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_CL = 4'd6;
  localparam logic [3:0] S_CR = 4'd7;
  localparam logic [3:0] S_RES = 4'd8;
  localparam logic [3:0] S_FCHK = 4'd9;
  localparam logic [3:0] S_MRG = 4'd10;
  localparam logic [3:0] S_RL = 4'd11;
  localparam logic [3:0] S_RR = 4'd12;
  localparam logic [3:0] S_MCHK = 4'd13;
  localparam logic [3:0] S_WRA = 4'd14;
  localparam logic [3:0] S_WPF = 4'd15;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLR;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op = OP_NOP;
    cmd.res = RS_OK;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_LOAD;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.kind ? sts.bad : sts.big) begin
          cmd.op = OP_RESULT;
          cmd.res = sts.kind ? RS_BADFREE : RS_NOFIT;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_RD_IDX;
          state_next = sts.kind ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts.rd == ST_FREE) begin
          state_next = S_SPLIT;
        end else if (sts.scan_last && sts.scan_final) begin
          cmd.op = OP_RESULT;
          cmd.res = RS_NOFIT;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_NEXT;
          state_next = S_ARD;
        end
      end
      S_ARD: begin
        cmd.op = OP_RD_IDX;
        state_next = S_ACHK;
      end
      S_SPLIT: begin
        if (sts.cur_gt) begin
          cmd.op = OP_W_SPLIT;
          state_next = S_CL;
        end else begin
          cmd.op = OP_W_USED;
          state_next = S_RES;
        end
      end
      S_CL: begin
        cmd.op = OP_W_CL;
        state_next = S_CR;
      end
      S_CR: begin
        cmd.op = OP_W_CR;
        state_next = S_SPLIT;
      end
      S_RES: begin
        cmd.op = OP_RESULT;
        state_next = S_IDLE;
      end
      S_FCHK: begin
        if (sts.rd != ST_USED) begin
          cmd.op = OP_RESULT;
          cmd.res = RS_BADFREE;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_W_FREE;
          state_next = S_MRG;
        end
      end
      S_MRG: begin
        if (sts.idx_zero) begin
          cmd.op = OP_RESULT;
          state_next = S_IDLE;
        end else begin
          cmd.op = OP_PAR;
          state_next = S_RL;
        end
      end
      S_RL: begin
        cmd.op = OP_RD_L;
        state_next = S_RR;
      end
      S_RR: begin
        cmd.op = OP_RD_R;
        state_next = S_MCHK;
      end
      S_MCHK: begin
        if (sts.lfree && sts.rd == ST_FREE) begin
          cmd.op = OP_W_LA;
          state_next = S_WRA;
        end else begin
          cmd.op = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      S_WRA: begin
        cmd.op = OP_W_RA;
        state_next = S_WPF;
      end
      S_WPF: begin
        cmd.op = OP_W_PF;
        state_next = S_MRG;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/buddy_block_allocator.sv =====
// top level of the buddy block allocator
// depends on bba_pkg, bba_ctrl and bba_dp
//
// A request is taken when start is high and busy is low; its one result appears
// with done high for a single cycle and cannot be held off. After reset the
// node memory is cleared, one node a cycle, all 2047 nodes, with busy high.
// The node memory has one read port with registered data, so each node looked
// at takes a read state and then a check state. An allocate scans nodes from the
// wanted order upward, then splits levels down; a free merges buddy levels up.
// A rejected size or a malformed free is answered from the decode state,
// without a read of the node memory.
`default_nettype none
module buddy_block_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind,
  input  wire logic [15:0] request_size,
  input  wire logic [9:0]  block_start,
  input  wire logic [3:0]  block_order,
  output logic             done,
  output logic [1:0]       status,
  output logic [9:0]       out_start,
  output logic [3:0]       out_order
);
  import bba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bba_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
  );

  bba_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .kind(kind), .request_size(request_size), .block_start(block_start),
    .block_order(block_order), .done(done), .status(status),
    .out_start(out_start), .out_order(out_order)
  );
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for buddy_block_allocator: directed and random allocate/free traffic
// keeps its own binary-tree allocation predictor; depends on bba_pkg and the allocator rtl
`timescale 1ns / 100ps
module tb;
  import bba_pkg::*;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int QUIET_TAIL = 200;

  typedef struct {
    logic [1:0]    status;
    logic [SW-1:0] blk_start;
    logic [OW-1:0] blk_order;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [1:0] tree [NODE_COUNT];
    alloc_result_t pending [$];
    int errors;

    function new();
      foreach (tree[i]) tree[i] = ST_ABSENT;
      tree[0] = ST_FREE;
      errors = 0;
    endfunction

    function alloc_result_t predict_alloc(int unsigned size);
      alloc_result_t r;
      int unsigned want, idx, cur;
      r = '{RS_NOFIT, '0, '0};
      if (size > (1 << TOP_ORDER)) return r;
      want = 0;
      while (want < TOP_ORDER && (1 << want) < size) want++;
      for (int unsigned o = want; o <= TOP_ORDER; o++) begin
        for (int unsigned p = 0; p < (1 << (TOP_ORDER - o)); p++) begin
          idx = (1 << (TOP_ORDER - o)) - 1 + p;
          if (tree[idx] == ST_FREE) begin
            cur = o;
            while (cur > want) begin
              tree[idx] = ST_SPLIT;
              tree[2*idx+1] = ST_FREE;
              tree[2*idx+2] = ST_FREE;
              idx = 2*idx + 1;
              cur--;
            end
            tree[idx] = ST_USED;
            r.status = RS_OK;
            r.blk_start = SW'((idx - ((1 << (TOP_ORDER - want)) - 1)) << want);
            r.blk_order = OW'(want);
            return r;
          end
        end
      end
      return r;
    endfunction

    function alloc_result_t predict_free(int unsigned bstart, int unsigned bord);
      alloc_result_t r;
      int unsigned idx, par, l;
      r = '{RS_BADFREE, '0, '0};
      if (bord > TOP_ORDER) return r;
      if ((bstart & ((1 << bord) - 1)) != 0) return r;
      if ((bstart >> bord) >= (1 << (TOP_ORDER - bord))) return r;
      idx = (1 << (TOP_ORDER - bord)) - 1 + (bstart >> bord);
      if (tree[idx] != ST_USED) return r;
      tree[idx] = ST_FREE;
      while (idx > 0) begin
        par = (idx - 1) / 2;
        l = 2*par + 1;
        if (tree[l] == ST_FREE && tree[l+1] == ST_FREE) begin
          tree[l] = ST_ABSENT;
          tree[l+1] = ST_ABSENT;
          tree[par] = ST_FREE;
          idx = par;
        end else begin
          break;
        end
      end
      r.status = RS_OK;
      return r;
    endfunction

    function alloc_result_t note_request(logic k, logic [15:0] size, logic [9:0] bstart,
                                         logic [3:0] bord);
      alloc_result_t r;
      if (k == KIND_ALLOC) r = predict_alloc(size);
      else r = predict_free(bstart, bord);
      pending.push_back(r);
      return r;
    endfunction

    task report(string what, int got, int want);
      if (errors < 30) $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [1:0] st, logic [SW-1:0] bs, logic [OW-1:0] bo);
      alloc_result_t e;
      if (pending.size() == 0) begin
        report("unexpected transaction, status", st, -1);
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) report("status", st, e.status);
      if (bs !== e.blk_start) report("out_start", bs, e.blk_start);
      if (bo !== e.blk_order) report("out_order", bo, e.blk_order);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic kind = KIND_ALLOC;
  logic [15:0] request_size = '0;
  logic [9:0] block_start = '0;
  logic [3:0] block_order = '0;
  logic busy, done;
  logic [1:0] status;
  logic [9:0] out_start;
  logic [3:0] out_order;

  alloc_scoreboard sb = new();
  logic [SW+OW-1:0] live_blocks [$];
  int idle_cycles = 0;

  buddy_block_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .request_size(request_size), .block_start(block_start), .block_order(block_order),
    .done(done), .status(status), .out_start(out_start), .out_order(out_order)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, out_start, out_order);
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task send(logic k, logic [15:0] size, logic [9:0] bstart, logic [3:0] bord);
    alloc_result_t r;
    int n;
    start <= 1'b1;
    kind <= k;
    request_size <= size;
    block_start <= bstart;
    block_order <= bord;
    do @(posedge clk); while (busy);
    r = sb.note_request(k, size, bstart, bord);
    if (k == KIND_ALLOC && r.status == RS_OK) begin
      live_blocks.push_back({r.blk_start, r.blk_order});
    end else if (k == KIND_FREE && r.status == RS_OK) begin
      n = -1;
      foreach (live_blocks[i]) if (live_blocks[i] == {bstart, bord}) n = i;
      if (n >= 0) live_blocks.delete(n);
    end
  endtask

  task pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending.size() != 0);
  endtask

  task send_random();
    int sel, ord, pick;
    logic [SW+OW-1:0] blk;
    sel = $urandom_range(99);
    if (sel < 45 || live_blocks.size() == 0) begin
      if ($urandom_range(19) == 0) begin
        send(KIND_ALLOC, 16'($urandom), 10'($urandom), 4'($urandom));
      end else begin
        ord = ($urandom_range(9) == 0) ? $urandom_range(10) : $urandom_range(7, 2);
        send(KIND_ALLOC, 16'($urandom_range(1 << ord, (ord == 0) ? 0 : (1 << (ord - 1)) + 1)),
             10'($urandom), 4'($urandom));
      end
    end else if (sel < 90) begin
      pick = $urandom_range(live_blocks.size() - 1);
      blk = live_blocks[pick];
      send(KIND_FREE, 16'($urandom), blk[SW+OW-1:OW], blk[OW-1:0]);
    end else begin
      send(KIND_FREE, 16'($urandom), 10'($urandom), 4'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send(KIND_ALLOC, 16'd1024, 10'd0, 4'd0);
    send(KIND_ALLOC, 16'd1, 10'd0, 4'd0);
    send(KIND_FREE, 16'd0, 10'd0, 4'd10);
    send(KIND_ALLOC, 16'd0, 10'd0, 4'd0);
    send(KIND_ALLOC, 16'd1, 10'd0, 4'd0);
    send(KIND_ALLOC, 16'd3, 10'd0, 4'd0);
    send(KIND_FREE, 16'd0, 10'd1, 4'd0);
    send(KIND_FREE, 16'd0, 10'd1, 4'd0);
    send(KIND_FREE, 16'd0, 10'd2, 4'd1);
    send(KIND_FREE, 16'd0, 10'd0, 4'd11);
    send(KIND_FREE, 16'hffff, 10'h3ff, 4'd15);
    send(KIND_FREE, 16'd0, 10'd512, 4'd10);
    send(KIND_ALLOC, 16'hffff, 10'd0, 4'd0);
    send(KIND_ALLOC, 16'd1025, 10'd0, 4'd0);
    send(KIND_ALLOC, 16'd513, 10'd0, 4'd0);
    send(KIND_FREE, 16'd0, 10'd0, 4'd0);
    send(KIND_FREE, 16'd0, 10'd4, 4'd2);
    send(KIND_ALLOC, 16'd512, 10'd0, 4'd0);
    send(KIND_ALLOC, 16'd512, 10'd0, 4'd0);
    send(KIND_FREE, 16'd0, 10'd512, 4'd9);
    send(KIND_FREE, 16'd0, 10'd0, 4'd9);
    send(KIND_ALLOC, 16'd1024, 10'd0, 4'd0);
    send(KIND_FREE, 16'd0, 10'd0, 4'd10);
    drain();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(7) == 0) pause($urandom_range(14, 1));
      send_random();
    end
    drain();
    repeat (50) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("results left over", sb.pending.size(), 0);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_dp.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator.sv
tb/tb.sv
